### rtl/c2p_pkg.sv
// ----------------------------------------------------------------------------
// c2p_pkg
// Shared constants, types and the arctangent table for the Cartesian-to-polar
// converter.
// ----------------------------------------------------------------------------
package c2p_pkg;

    // Defaults for the top-level parameters
    localparam int SAMPLE_WIDTH_DEF  = 16;
    localparam int CORDIC_STAGES_DEF = 18;

    // Angle accumulator: unsigned turns, 2^TURN_BITS = one full turn
    localparam int TURN_BITS  = 24;
    // Fraction bits below the sample LSB in the rotation datapath
    localparam int GUARD_BITS = 24;
    // Entries in the arctangent table, also the cap on rotation stages
    localparam int ATAN_LEN   = 32;
    // Headroom bits above the scaled sample (negation, CORDIC gain, sqrt 2)
    localparam int HEAD_BITS  = 3;

    localparam int THETA_WIDTH  = 16;
    localparam int RADIUS_WIDTH = 16;

    // APB port
    localparam int APB_DATA_WIDTH = 32;
    localparam int CFG_ADDR_WIDTH = 3;

    localparam logic [THETA_WIDTH-1:0] THETA_MAX_RESET = 16'd255;

    typedef logic [TURN_BITS-1:0] t_turns;

    // Register index codes
    typedef enum logic [CFG_ADDR_WIDTH-3:0] {
        REG_THETA_MAX = 1'b0
    } t_cfg_reg;

    localparam t_turns TURN_ZERO    = '0;
    localparam t_turns TURN_QUARTER = t_turns'(1 << (TURN_BITS - 2));
    localparam t_turns TURN_HALF    = t_turns'(1 << (TURN_BITS - 1));
    localparam t_turns TURN_3QUART  = t_turns'(3 << (TURN_BITS - 2));

    // round(atan(2^-i) * 2^24 / (2*pi))
    localparam t_turns ATAN_TURNS [ATAN_LEN] = '{
        24'd2097152, 24'd1238021, 24'd654136, 24'd332050,
        24'd166669,  24'd83416,   24'd41718,  24'd20860,
        24'd10430,   24'd5215,    24'd2608,   24'd1304,
        24'd652,     24'd326,     24'd163,    24'd81,
        24'd41,      24'd20,      24'd10,     24'd5,
        24'd3,       24'd1,       24'd1,      24'd0,
        24'd0,       24'd0,       24'd0,      24'd0,
        24'd0,       24'd0,       24'd0,      24'd0
    };

    // Axis override: angle fixed without the rotation result
    typedef struct packed {
        logic   forced;
        t_turns forced_turns;
    } t_sel;

endpackage

### rtl/c2p_if.sv
// ----------------------------------------------------------------------------
// c2p_if
// Valid/ready stream interfaces for the pixel input and the polar result.
// ----------------------------------------------------------------------------
interface c2p_in_if
    import c2p_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] x_value;
    logic signed [SAMPLE_WIDTH-1:0] y_value;

    modport source (output valid, output x_value, output y_value, input ready);
    modport sink   (input valid, input x_value, input y_value, output ready);
endinterface

interface c2p_out_if
    import c2p_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [THETA_WIDTH-1:0]  theta_out;
    logic [RADIUS_WIDTH-1:0] radius_out;

    modport source (output valid, output theta_out, output radius_out, input ready);
    modport sink   (input valid, input theta_out, input radius_out, output ready);
endinterface

### rtl/c2p_apb.sv
// ----------------------------------------------------------------------------
// c2p_apb
// APB register file: holds theta_max.
// ----------------------------------------------------------------------------
module c2p_apb
    import c2p_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [CFG_ADDR_WIDTH-1:0] paddr,
    input  logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic [APB_DATA_WIDTH-1:0] prdata,
    output logic                      pready,
    output logic [THETA_WIDTH-1:0]    o_theta_max
);

    logic [THETA_WIDTH-1:0] r_theta_max;
    logic                   sel_theta_max;

    assign sel_theta_max = (paddr[CFG_ADDR_WIDTH-1:2] == REG_THETA_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_theta_max <= THETA_MAX_RESET;
        end else if (psel && penable && pwrite && sel_theta_max) begin
            r_theta_max <= pwdata[THETA_WIDTH-1:0];
        end
    end

    assign pready      = 1'b1;
    assign prdata      = sel_theta_max ? APB_DATA_WIDTH'(r_theta_max) : '0;
    assign o_theta_max = r_theta_max;

endmodule

### rtl/c2p_prep.sv
// ----------------------------------------------------------------------------
// c2p_prep
// Two front stages: squares of |x| and |y|, then axis detection, half-plane
// pre-rotation, guard-bit scaling and the sum of squares.
// ----------------------------------------------------------------------------
module c2p_prep
    import c2p_pkg::*;
#(
    parameter int SW = SAMPLE_WIDTH_DEF,
    parameter int W  = SAMPLE_WIDTH_DEF + GUARD_BITS + HEAD_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // upstream
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [SW-1:0] i_x,
    input  logic signed [SW-1:0] i_y,
    // downstream
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [W-1:0] o_x,
    output logic signed [W-1:0] o_y,
    output t_turns              o_z,
    output t_sel                o_sel,
    output logic [SW+1:0]       o_rem,
    output logic [SW-1:0]       o_root,
    output logic [2*SW-1:0]     o_nsq
);

    // ---- stage A: squares
    logic                 r_a_v;
    logic signed [SW-1:0] r_a_x, r_a_y;
    logic [2*SW-1:0]      r_a_sqx, r_a_sqy;
    logic [SW-1:0]        n_ax, n_ay;
    logic [2*SW-1:0]      n_axw, n_ayw;
    logic                 a_ready;

    // ---- stage B: pre-rotation
    logic                 r_b_v;
    logic signed [W-1:0]  r_b_x, r_b_y;
    t_turns               r_b_z;
    t_sel                 r_b_sel;
    logic [2*SW-1:0]      r_b_nsq;
    logic signed [W-1:0]  n_cx, n_cy;
    t_turns               n_z;
    t_sel                 n_sel;
    logic                 b_ready;

    // two's complement negate gives the right unsigned magnitude at the minimum
    assign n_ax  = i_x[SW-1] ? SW'(-i_x) : SW'(i_x);
    assign n_ay  = i_y[SW-1] ? SW'(-i_y) : SW'(i_y);
    assign n_axw = {{SW{1'b0}}, n_ax};
    assign n_ayw = {{SW{1'b0}}, n_ay};

    assign a_ready = !r_a_v || b_ready;
    assign o_ready = a_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (a_ready) begin
            r_a_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_a_x   <= i_x;
            r_a_y   <= i_y;
            r_a_sqx <= n_axw * n_axw;
            r_a_sqy <= n_ayw * n_ayw;
        end
    end

    always_comb begin
        n_cx = {{(W-SW-GUARD_BITS){r_a_x[SW-1]}}, r_a_x, {GUARD_BITS{1'b0}}};
        n_cy = {{(W-SW-GUARD_BITS){r_a_y[SW-1]}}, r_a_y, {GUARD_BITS{1'b0}}};
        n_z  = TURN_ZERO;
        if (r_a_x[SW-1]) begin
            n_cx = -n_cx;
            n_cy = -n_cy;
            n_z  = TURN_HALF;
        end

        n_sel.forced       = 1'b0;
        n_sel.forced_turns = TURN_ZERO;
        if (r_a_y == '0) begin
            n_sel.forced       = 1'b1;
            n_sel.forced_turns = r_a_x[SW-1] ? TURN_HALF : TURN_ZERO;
        end else if (r_a_x == '0) begin
            n_sel.forced       = 1'b1;
            n_sel.forced_turns = r_a_y[SW-1] ? TURN_3QUART : TURN_QUARTER;
        end
    end

    assign b_ready = !r_b_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (b_ready) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready && r_a_v) begin
            r_b_x   <= n_cx;
            r_b_y   <= n_cy;
            r_b_z   <= n_z;
            r_b_sel <= n_sel;
            r_b_nsq <= r_a_sqx + r_a_sqy;
        end
    end

    assign o_valid = r_b_v;
    assign o_x     = r_b_x;
    assign o_y     = r_b_y;
    assign o_z     = r_b_z;
    assign o_sel   = r_b_sel;
    assign o_nsq   = r_b_nsq;
    // square root recurrence starts from zero
    assign o_rem   = '0;
    assign o_root  = '0;

endmodule

### rtl/c2p_stage.sv
// ----------------------------------------------------------------------------
// c2p_stage
// One pipeline stage: one CORDIC vectoring iteration and one digit of the
// restoring integer square root, each present only where the index calls.
// ----------------------------------------------------------------------------
module c2p_stage
    import c2p_pkg::*;
#(
    parameter int SW      = SAMPLE_WIDTH_DEF,
    parameter int W       = SAMPLE_WIDTH_DEF + GUARD_BITS + HEAD_BITS,
    parameter int IDX     = 0,
    parameter bit DO_ROT  = 1'b1,
    parameter bit DO_SQRT = 1'b1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [W-1:0] i_x,
    input  logic signed [W-1:0] i_y,
    input  t_turns              i_z,
    input  t_sel                i_sel,
    input  logic [SW+1:0]       i_rem,
    input  logic [SW-1:0]       i_root,
    input  logic [2*SW-1:0]     i_nsq,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [W-1:0] o_x,
    output logic signed [W-1:0] o_y,
    output t_turns              o_z,
    output t_sel                o_sel,
    output logic [SW+1:0]       o_rem,
    output logic [SW-1:0]       o_root,
    output logic [2*SW-1:0]     o_nsq
);

    logic                r_v;
    logic signed [W-1:0] r_x, r_y;
    t_turns              r_z;
    t_sel                r_sel;
    logic [SW+1:0]       r_rem;
    logic [SW-1:0]       r_root;
    logic [2*SW-1:0]     r_nsq;

    logic signed [W-1:0] n_x, n_y;
    t_turns              n_z;
    logic [SW+1:0]       n_rem;
    logic [SW-1:0]       n_root;
    logic [2*SW-1:0]     n_nsq;

    generate
        if (DO_ROT) begin : g_rot
            logic signed [W-1:0] dx, dy;
            logic                y_pos;
            assign dx    = i_y >>> IDX;
            assign dy    = i_x >>> IDX;
            assign y_pos = !i_y[W-1] && (i_y != '0);
            always_comb begin
                if (y_pos) begin
                    n_x = i_x + dx;
                    n_y = i_y - dy;
                    n_z = i_z + ATAN_TURNS[IDX];
                end else begin
                    n_x = i_x - dx;
                    n_y = i_y + dy;
                    n_z = i_z - ATAN_TURNS[IDX];
                end
            end
        end else begin : g_no_rot
            assign n_x = i_x;
            assign n_y = i_y;
            assign n_z = i_z;
        end

        if (DO_SQRT) begin : g_sqrt
            logic [SW+1:0] rem_sh, trial;
            // remainder stays below 2^SW before the shift
            assign rem_sh = {i_rem[SW-1:0], i_nsq[2*SW-1 -: 2]};
            assign trial  = {i_root, 2'b01};
            always_comb begin
                if (rem_sh >= trial) begin
                    n_rem  = rem_sh - trial;
                    n_root = {i_root[SW-2:0], 1'b1};
                end else begin
                    n_rem  = rem_sh;
                    n_root = {i_root[SW-2:0], 1'b0};
                end
                n_nsq = {i_nsq[2*SW-3:0], 2'b00};
            end
        end else begin : g_no_sqrt
            assign n_rem  = i_rem;
            assign n_root = i_root;
            assign n_nsq  = i_nsq;
        end
    endgenerate

    assign o_ready = !r_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_sel  <= i_sel;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_nsq  <= n_nsq;
        end
    end

    assign o_valid = r_v;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_sel   = r_sel;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_nsq   = r_nsq;

endmodule

### rtl/c2p_post.sv
// ----------------------------------------------------------------------------
// c2p_post
// Output stage: axis override, scaling of turns by theta_max, radius clamp or
// widening, and the result register.
// ----------------------------------------------------------------------------
module c2p_post
    import c2p_pkg::*;
#(
    parameter int SW = SAMPLE_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  t_turns                  i_z,
    input  t_sel                    i_sel,
    input  logic [SW-1:0]           i_root,
    input  logic [THETA_WIDTH-1:0]  i_theta_max,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [THETA_WIDTH-1:0]  o_theta,
    output logic [RADIUS_WIDTH-1:0] o_radius
);

    localparam int PROD_WIDTH = TURN_BITS + THETA_WIDTH;

    logic                    r_v;
    logic [THETA_WIDTH-1:0]  r_theta;
    logic [RADIUS_WIDTH-1:0] r_radius;

    t_turns                  angle;
    logic [PROD_WIDTH-1:0]   n_prod;
    logic [RADIUS_WIDTH-1:0] n_radius;

    assign angle  = i_sel.forced ? i_sel.forced_turns : i_z;
    assign n_prod = PROD_WIDTH'(angle) * PROD_WIDTH'(i_theta_max);

    generate
        if (SW > RADIUS_WIDTH) begin : g_clamp
            assign n_radius = (|i_root[SW-1:RADIUS_WIDTH]) ? '1
                                                           : i_root[RADIUS_WIDTH-1:0];
        end else begin : g_widen
            assign n_radius = RADIUS_WIDTH'(i_root);
        end
    endgenerate

    assign o_ready = !r_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_theta  <= n_prod[PROD_WIDTH-1:TURN_BITS];
            r_radius <= n_radius;
        end
    end

    assign o_valid  = r_v;
    assign o_theta  = r_theta;
    assign o_radius = r_radius;

endmodule

### rtl/cartesian_to_polar_scaled.sv
// ----------------------------------------------------------------------------
// cartesian_to_polar_scaled
// Streaming Cartesian-to-polar converter: CORDIC vectoring angle scaled to
// theta_max per turn, exact truncated radius by a digit-per-stage square root.
// ----------------------------------------------------------------------------
// Pipeline: two front stages, one stage per CORDIC iteration / root digit,
//   then the output stage.
// Throughput: one transfer per clock while o_pol.ready is high; each stage
//   holds its own valid bit, so bubbles close up under output backpressure.
// Reset (i_rst_n low, synchronous): all valid bits clear, theta_max = 255.
//   No memories, no clearing pass.
// ----------------------------------------------------------------------------
module cartesian_to_polar_scaled
    import c2p_pkg::*;
#(
    parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // pixel stream in
    c2p_in_if.sink                    i_pix,
    // polar stream out
    c2p_out_if.source                 o_pol,
    // configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [CFG_ADDR_WIDTH-1:0] paddr,
    input  logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic [APB_DATA_WIDTH-1:0] prdata,
    output logic                      pready
);

    // Iterations past the table end would add nothing; cap them.
    localparam int ROT_STAGES  = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
    // Rotation and root share one stage chain; the longer one sets its length.
    localparam int PIPE_STAGES = (ROT_STAGES > SAMPLE_WIDTH) ? ROT_STAGES : SAMPLE_WIDTH;
    // Rotation word: sample, guard fraction, headroom for negation and gain.
    localparam int W           = SAMPLE_WIDTH + GUARD_BITS + HEAD_BITS;

    // Chain taps: index k feeds stage k, index PIPE_STAGES feeds the output.
    logic                      s_valid [PIPE_STAGES+1];
    logic                      s_ready [PIPE_STAGES+1];
    logic signed [W-1:0]       s_x     [PIPE_STAGES+1];
    logic signed [W-1:0]       s_y     [PIPE_STAGES+1];
    t_turns                    s_z     [PIPE_STAGES+1];
    t_sel                      s_sel   [PIPE_STAGES+1];
    logic [SAMPLE_WIDTH+1:0]   s_rem   [PIPE_STAGES+1];
    logic [SAMPLE_WIDTH-1:0]   s_root  [PIPE_STAGES+1];
    logic [2*SAMPLE_WIDTH-1:0] s_nsq   [PIPE_STAGES+1];

    logic [THETA_WIDTH-1:0]    theta_max;

    // ---- configuration registers
    c2p_apb u_apb (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_theta_max (theta_max)
    );

    // ---- front end: squares, axis cases, left-half-plane flip
    c2p_prep #(
        .SW (SAMPLE_WIDTH),
        .W  (W)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pix.valid),
        .o_ready (i_pix.ready),
        .i_x     (i_pix.x_value),
        .i_y     (i_pix.y_value),
        .o_valid (s_valid[0]),
        .i_ready (s_ready[0]),
        .o_x     (s_x[0]),
        .o_y     (s_y[0]),
        .o_z     (s_z[0]),
        .o_sel   (s_sel[0]),
        .o_rem   (s_rem[0]),
        .o_root  (s_root[0]),
        .o_nsq   (s_nsq[0])
    );

    // ---- iteration chain: stage k rotates by atan(2^-k) below ROT_STAGES and
    //      settles one root bit below SAMPLE_WIDTH, most significant first
    for (genvar k = 0; k < PIPE_STAGES; k++) begin : g_stage
        c2p_stage #(
            .SW      (SAMPLE_WIDTH),
            .W       (W),
            .IDX     (k),
            .DO_ROT  (k < ROT_STAGES),
            .DO_SQRT (k < SAMPLE_WIDTH)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[k]),
            .o_ready (s_ready[k]),
            .i_x     (s_x[k]),
            .i_y     (s_y[k]),
            .i_z     (s_z[k]),
            .i_sel   (s_sel[k]),
            .i_rem   (s_rem[k]),
            .i_root  (s_root[k]),
            .i_nsq   (s_nsq[k]),
            .o_valid (s_valid[k+1]),
            .i_ready (s_ready[k+1]),
            .o_x     (s_x[k+1]),
            .o_y     (s_y[k+1]),
            .o_z     (s_z[k+1]),
            .o_sel   (s_sel[k+1]),
            .o_rem   (s_rem[k+1]),
            .o_root  (s_root[k+1]),
            .o_nsq   (s_nsq[k+1])
        );
    end

    // ---- output: turns * theta_max >> 24, radius clamp, result register.
    //      The final rotated x/y and the root remainder are not needed here.
    c2p_post #(
        .SW (SAMPLE_WIDTH)
    ) u_post (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_valid[PIPE_STAGES]),
        .o_ready     (s_ready[PIPE_STAGES]),
        .i_z         (s_z[PIPE_STAGES]),
        .i_sel       (s_sel[PIPE_STAGES]),
        .i_root      (s_root[PIPE_STAGES]),
        .i_theta_max (theta_max),
        .o_valid     (o_pol.valid),
        .i_ready     (o_pol.ready),
        .o_theta     (o_pol.theta_out),
        .o_radius    (o_pol.radius_out)
    );

endmodule

### rtl/c2p_checker.sv
// ----------------------------------------------------------------------------
// c2p_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
module c2p_checker
    import c2p_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [THETA_WIDTH-1:0]    i_theta_out,
    input logic [RADIUS_WIDTH-1:0]   i_radius_out,
    input logic                      i_psel,
    input logic                      i_penable,
    input logic                      i_pwrite,
    input logic                      i_pready,
    input logic [CFG_ADDR_WIDTH-1:0] i_paddr,
    input logic [APB_DATA_WIDTH-1:0] i_pwdata
);

    // shadow of theta_max, tracked from the APB writes
    logic [THETA_WIDTH-1:0] r_theta_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_theta_max <= THETA_MAX_RESET;
        end else if (i_psel && i_penable && i_pwrite && i_pready
                     && (i_paddr[CFG_ADDR_WIDTH-1:2] == REG_THETA_MAX)) begin
            r_theta_max <= i_pwdata[THETA_WIDTH-1:0];
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_theta_out) && $stable(i_radius_out)))
        else $error("result changed while stalled");

    // an empty output register means the whole chain can move
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    a_theta_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (r_theta_max != '0)) |-> (i_theta_out < r_theta_max))
        else $error("theta_out not below theta_max");

    a_theta_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (r_theta_max == '0)) |-> (i_theta_out == '0))
        else $error("theta_out nonzero with zero theta_max");

endmodule

bind cartesian_to_polar_scaled c2p_checker u_c2p_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_pix.valid),
    .i_in_ready   (i_pix.ready),
    .i_out_valid  (o_pol.valid),
    .i_out_ready  (o_pol.ready),
    .i_theta_out  (o_pol.theta_out),
    .i_radius_out (o_pol.radius_out),
    .i_psel       (psel),
    .i_penable    (penable),
    .i_pwrite     (pwrite),
    .i_pready     (pready),
    .i_paddr      (paddr),
    .i_pwdata     (pwdata)
);
